// ===== hw/rtl/pidd_pkg.sv =====
package pidd_pkg;

	// Fixed-point format and state widths.
	localparam int FRAC_BITS   = 16;
	localparam int INTEG_WIDTH = 48;
	localparam int DATA_W      = 32;
	localparam int CFG_IDX_W   = 3;

	// Shared multiplier: signed operands, one guard bit over the data width.
	localparam int MUL_W  = DATA_W + 1;
	localparam int PROD_W = 2 * MUL_W;

	// The integrator is multiplied in two halves; the low half is unsigned.
	localparam int INT_LO_W = INTEG_WIDTH / 2;
	localparam int INT_HI_W = INTEG_WIDTH - INT_LO_W;

	// Wide product accumulator, holds ki times the whole integrator exactly.
	localparam int PACC_W = INTEG_WIDTH + 34;

	localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

	localparam logic FUNC_UPDATE = 1'b0;
	localparam logic FUNC_RESET  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KP         = 3'd0,
		CFG_KI         = 3'd1,
		CFG_KD         = 3'd2,
		CFG_OUT_MIN    = 3'd3,
		CFG_OUT_MAX    = 3'd4,
		CFG_HALF_TS    = 3'd5,
		CFG_BETA       = 3'd6,
		CFG_DERIV_GAIN = 3'd7
	} pidd_cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_INT,
		ST_MUL_BETA,
		ST_MUL_DGAIN,
		ST_MUL_KIHI,
		ST_MUL_KILO,
		ST_MUL_KP,
		ST_MUL_KD,
		ST_ACC_KD,
		ST_CLAMP
	} pidd_state_t;

	// Arithmetic shift right by the fraction width (floor), saturated to 64 bits.
	function automatic logic signed [63:0] shift_sat(input logic signed [PACC_W-1:0] x);
		logic signed [PACC_W-1:0] y;
		logic [PACC_W-64:0]       top;
		y   = x >>> FRAC_BITS;
		top = y[PACC_W-1:63];
		if ((&top) || !(|top)) begin
			return y[63:0];
		end
		return y[PACC_W-1] ? S64_MIN : S64_MAX;
	endfunction

	function automatic logic signed [63:0] sat64(input logic signed [64:0] x);
		if (x[64] != x[63]) begin
			return x[64] ? S64_MIN : S64_MAX;
		end
		return x[63:0];
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [64:0] x);
		logic [33:0] top;
		top = x[64:31];
		if ((&top) || !(|top)) begin
			return x[31:0];
		end
		return x[64] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
	endfunction

	function automatic logic signed [INTEG_WIDTH-1:0] clamp_integ(
		input logic signed [65:0] x
	);
		logic [66-INTEG_WIDTH:0] top;
		top = x[65:INTEG_WIDTH-1];
		if ((&top) || !(|top)) begin
			return x[INTEG_WIDTH-1:0];
		end
		return x[65] ? {1'b1, {(INTEG_WIDTH-1){1'b0}}} : {1'b0, {(INTEG_WIDTH-1){1'b1}}};
	endfunction

	// Sign-extend a raw product to the accumulator width.
	function automatic logic signed [PACC_W-1:0] prod_ext(input logic signed [PROD_W-1:0] p);
		return {{(PACC_W-PROD_W){p[PROD_W-1]}}, p};
	endfunction

endpackage

// ===== hw/rtl/pidd_mul.sv =====
module pidd_mul
	import pidd_pkg::*;
(
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  op_a,
	input  logic signed [MUL_W-1:0]  op_b,
	output logic signed [PROD_W-1:0] prod_q
);

	// Signed multiply with the product registered before any further use.
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule

// ===== hw/rtl/pid_dirty_derivative_saturating.sv =====
// An update word is taken only when idle; the input stalls until its result is loaded,
// which waits while an earlier result is held at the output. A reset word leaves the
// block idle. Updates are paced by the single shared 33 x 33 multiplier, used seven
// times per update under a small sequencer, plus a final saturation and clamp step.
// Reset (arst_n low) clears the controller state and loads the register defaults:
// all gains zero and the output limits at the full 32-bit range.
module pid_dirty_derivative_saturating
	import pidd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0]     cfg_data,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  func,
	input  logic signed [31:0]    setpoint,
	input  logic signed [31:0]    measurement,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [31:0]    control_out
);

	// Configuration registers.
	logic signed [31:0] kp_q, ki_q, kd_q, out_min_q, out_max_q, deriv_gain_q;
	logic        [30:0] half_ts_q;
	logic signed [17:0] beta_q;

	// Controller state carried from one word to the next.
	logic signed [31:0]             prev_q;
	logic signed [INTEG_WIDTH-1:0]  integ_q;
	logic signed [31:0]             rate_q;

	// Working registers for the word in flight.
	logic signed [31:0]       err_q;
	logic signed [32:0]       esum_q;
	logic signed [32:0]       ediff_q;
	logic signed [63:0]       racc_q;
	logic signed [PACC_W-1:0] pacc_q;
	logic signed [63:0]       u_q;
	logic                     out_valid_q;
	logic signed [31:0]       control_out_q;

	pidd_state_t state_q, state_d;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_q;

	logic                     in_fire;
	logic                     out_fire;
	logic                     out_load;
	logic signed [32:0]       diff_in;
	logic signed [31:0]       err_in;
	logic signed [63:0]       term;
	logic signed [63:0]       u_hi_cut;
	logic signed [63:0]       lo64, up64;

	assign in_stall    = (state_q != ST_IDLE);
	assign in_fire     = in_valid && !in_stall;
	assign out_fire    = out_valid_q && !out_stall;
	assign out_valid   = out_valid_q;
	assign control_out = control_out_q;

	// The error is formed on acceptance and saturated to 32 bits.
	assign diff_in = {setpoint[31], setpoint} - {measurement[31], measurement};
	assign err_in  = clamp32({{32{diff_in[32]}}, diff_in});

	// Each product but the two ki halves is scaled back by the fraction width before use.
	assign term = shift_sat(prod_ext(prod_q));

	assign lo64     = {{32{out_min_q[31]}}, out_min_q};
	assign up64     = {{32{out_max_q[31]}}, out_max_q};
	assign u_hi_cut = (u_q > up64) ? up64 : u_q;

	// The result register must be free, or emptied this cycle, before loading.
	assign out_load = (state_q == ST_CLAMP) && (!out_valid_q || !out_stall);

	// Sequencer: each multiply step issues one product, which the step after it folds in.
	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && func == FUNC_UPDATE) begin
					state_d = ST_MUL_INT;
				end
			end
			ST_MUL_INT: begin
				mul_a   = {2'b00, half_ts_q};
				mul_b   = esum_q;
				state_d = ST_MUL_BETA;
			end
			ST_MUL_BETA: begin
				mul_a   = {{(MUL_W-18){beta_q[17]}}, beta_q};
				mul_b   = {rate_q[31], rate_q};
				state_d = ST_MUL_DGAIN;
			end
			ST_MUL_DGAIN: begin
				mul_a   = {deriv_gain_q[31], deriv_gain_q};
				mul_b   = ediff_q;
				state_d = ST_MUL_KIHI;
			end
			ST_MUL_KIHI: begin
				mul_a   = {ki_q[31], ki_q};
				mul_b   = {{(MUL_W-INT_HI_W){integ_q[INTEG_WIDTH-1]}},
					integ_q[INTEG_WIDTH-1:INT_LO_W]};
				state_d = ST_MUL_KILO;
			end
			ST_MUL_KILO: begin
				mul_a   = {ki_q[31], ki_q};
				mul_b   = {{(MUL_W-INT_LO_W){1'b0}}, integ_q[INT_LO_W-1:0]};
				state_d = ST_MUL_KP;
			end
			ST_MUL_KP: begin
				mul_a   = {kp_q[31], kp_q};
				mul_b   = {err_q[31], err_q};
				state_d = ST_MUL_KD;
			end
			ST_MUL_KD: begin
				mul_a   = {kd_q[31], kd_q};
				mul_b   = {rate_q[31], rate_q};
				state_d = ST_ACC_KD;
			end
			ST_ACC_KD: begin
				state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	pidd_mul u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (prod_q)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q         <= '0;
			ki_q         <= '0;
			kd_q         <= '0;
			out_min_q    <= {1'b1, {31{1'b0}}};
			out_max_q    <= {1'b0, {31{1'b1}}};
			half_ts_q    <= '0;
			beta_q       <= '0;
			deriv_gain_q <= '0;
		end else if (cfg_we) begin
			unique case (pidd_cfg_idx_t'(cfg_index))
				CFG_KP:         kp_q         <= cfg_data;
				CFG_KI:         ki_q         <= cfg_data;
				CFG_KD:         kd_q         <= cfg_data;
				CFG_OUT_MIN:    out_min_q    <= cfg_data;
				CFG_OUT_MAX:    out_max_q    <= cfg_data;
				CFG_HALF_TS:    half_ts_q    <= cfg_data[30:0];
				CFG_BETA:       beta_q       <= cfg_data[17:0];
				CFG_DERIV_GAIN: deriv_gain_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Controller state. A reset word clears the integrator and the filter and
	// seeds the previous error; an update word refreshes them as it goes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			integ_q <= '0;
			rate_q  <= '0;
		end else begin
			if (in_fire) begin
				prev_q <= err_in;
				if (func == FUNC_RESET) begin
					integ_q <= '0;
					rate_q  <= '0;
				end
			end
			if (state_q == ST_MUL_BETA) begin
				// Trapezoidal step: half_ts times the error sum, added with saturation.
				integ_q <= clamp_integ({{(66-INTEG_WIDTH){integ_q[INTEG_WIDTH-1]}}, integ_q}
					+ {{2{term[63]}}, term});
			end
			if (state_q == ST_MUL_KIHI) begin
				// Filtered derivative: pole term plus the scaled error difference.
				rate_q <= clamp32({racc_q[63], racc_q} + {term[63], term});
			end
		end
	end

	// Working registers; they carry payload only and need no reset.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			err_q   <= err_in;
			esum_q  <= {err_in[31], err_in} + {prev_q[31], prev_q};
			ediff_q <= {err_in[31], err_in} - {prev_q[31], prev_q};
		end
		case (state_q)
			ST_MUL_DGAIN: racc_q <= term;
			// The high half of ki times the integrator is weighted by the low half's width.
			ST_MUL_KILO:  pacc_q <= prod_ext(prod_q) <<< INT_LO_W;
			ST_MUL_KP:    u_q    <= shift_sat(pacc_q + prod_ext(prod_q));
			ST_MUL_KD,
			ST_ACC_KD:    u_q    <= sat64({u_q[63], u_q} + {term[63], term});
			default: begin
			end
		endcase
		// Upper limit first, then lower, so crossed limits give the lower one.
		if (out_load) begin
			control_out_q <= (u_hi_cut < lo64) ? out_min_q : u_hi_cut[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	// A reset word leaves the integrator and the filter cleared.
	a_reset_word_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func == FUNC_RESET |=> integ_q == '0 && rate_q == '0)
		else $error("reset word did not clear integrator and filter");

	// An update word keeps the input side busy on the following cycle.
	a_update_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func == FUNC_UPDATE |=> in_stall)
		else $error("input taken again straight after an update word");

	// Leaving the clamp step always presents a result.
	a_clamp_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLAMP && (!out_valid || !out_stall) |=> out_valid && !in_stall)
		else $error("clamp step finished without a result word");

endmodule

// ===== tb/tb_pid_dirty_derivative_saturating.sv =====
`timescale 1ns / 100ps

module tb_pid_dirty_derivative_saturating
	import pidd_pkg::*;
();

	// The watchdog gives up after this many cycles in which no word moves on
	// either channel. The long receiver hold-off is the largest legal pause.
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD      = 300;
	localparam int SETTLE_CYCLES  = 12;
	localparam int N_PHASES       = 8;
	localparam int PHASE_WORDS    = 175;
	localparam int N_DIR_ROWS     = 25;
	localparam int N_DIR_SETS     = 7;

	// Raw register contents, as they go onto cfg_data.
	typedef struct packed {
		logic [31:0] kp;
		logic [31:0] ki;
		logic [31:0] kd;
		logic [31:0] out_min;
		logic [31:0] out_max;
		logic [31:0] half_ts;
		logic [31:0] beta;
		logic [31:0] deriv_gain;
	} reg_set_t;

	// One row of the directed table. Where known is set, want is the word
	// that must come back; otherwise the predictor decides.
	typedef struct packed {
		logic [2:0]  set_no;
		logic        f;
		logic [31:0] sp;
		logic [31:0] ms;
		logic        known;
		logic [31:0] want;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 func;
	logic signed [31:0]   setpoint;
	logic signed [31:0]   measurement;
	logic                 out_valid;
	logic                 out_stall;
	logic signed [31:0]   control_out;

	pid_dirty_derivative_saturating dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.setpoint    (setpoint),
		.measurement (measurement),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.control_out (control_out)
	);

	// Control words still owed by the block, oldest first.
	logic signed [31:0] control_due [$];
	int                 fail_count = 0;
	int                 idle_cycles = 0;

	// Handshakes between the sender and the receiver processes.
	bit long_hold  = 1'b0;
	bit quiet      = 1'b0;
	bit burst_mode = 1'b0;

	// The predictor's own copy of the registers and the controller state.
	logic signed [31:0] kp_q, ki_q, kd_q, lo_lim_q, hi_lim_q, dgain_q;
	logic        [30:0] half_ts_q;
	logic signed [17:0] beta_q;
	logic signed [31:0] prev_err_q;
	logic signed [31:0] rate_q;
	logic signed [INTEG_WIDTH-1:0] integ_q;

	reg_set_t dir_sets [N_DIR_SETS];
	dir_row_t dir_rows [N_DIR_ROWS];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Exact product of two signed values, floored by the fraction width and
	// saturated to 64 bits.
	function automatic logic signed [63:0] mul_floor(
		input logic signed [63:0] a,
		input logic signed [63:0] b
	);
		logic signed [127:0] p;
		p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
		p = p >>> FRAC_BITS;
		if ((&p[127:63]) || !(|p[127:63])) begin
			return p[63:0];
		end
		return p[127] ? S64_MIN : S64_MAX;
	endfunction

	function automatic logic signed [63:0] add_sat(
		input logic signed [63:0] a,
		input logic signed [63:0] b
	);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? S64_MIN : S64_MAX;
		end
		return s[63:0];
	endfunction

	// Saturate a value to a signed range of w bits.
	function automatic logic signed [63:0] clip(input logic signed [63:0] v, input int w);
		logic signed [63:0] top;
		logic signed [63:0] bot;
		top = (64'sd1 <<< (w - 1)) - 64'sd1;
		bot = -top - 64'sd1;
		if (v > top) begin
			return top;
		end
		if (v < bot) begin
			return bot;
		end
		return v;
	endfunction

	// Advances the controller state by one word. Returns 1 when the word
	// gives a control output, which is then placed in u_out.
	function automatic bit predict_control(
		input  logic               f,
		input  logic signed [31:0] sp,
		input  logic signed [31:0] ms,
		output logic signed [31:0] u_out
	);
		logic signed [63:0] sp64, ms64, err, prev, u, lim_lo, lim_hi;
		sp64  = 64'(sp);
		ms64  = 64'(ms);
		err   = clip(sp64 - ms64, 32);
		prev  = 64'(prev_err_q);
		u_out = '0;
		if (f == FUNC_RESET) begin
			integ_q    = '0;
			rate_q     = '0;
			prev_err_q = err[31:0];
			return 1'b0;
		end
		// Trapezoidal integration, held within the integrator's width.
		integ_q = INTEG_WIDTH'(clip(add_sat(64'(integ_q),
			mul_floor({33'd0, half_ts_q}, err + prev)), INTEG_WIDTH));
		// One-pole filtered derivative.
		rate_q = 32'(clip(add_sat(mul_floor(64'(beta_q), 64'(rate_q)),
			mul_floor(64'(dgain_q), err - prev)), 32));
		u = add_sat(mul_floor(64'(kp_q), err), mul_floor(64'(ki_q), 64'(integ_q)));
		u = add_sat(u, mul_floor(64'(kd_q), 64'(rate_q)));
		lim_hi = 64'(hi_lim_q);
		lim_lo = 64'(lo_lim_q);
		// The lower limit is tested last, so crossed limits give the lower limit.
		if (u > lim_hi) begin
			u = lim_hi;
		end
		if (u < lim_lo) begin
			u = lim_lo;
		end
		prev_err_q = err[31:0];
		u_out      = u[31:0];
		return 1'b1;
	endfunction

	// Writes one register and keeps the predictor's copy in step. The write
	// enable is left high; the caller lowers it after the last write.
	task automatic write_reg(input pidd_cfg_idx_t idx, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			CFG_KP:         kp_q      = data;
			CFG_KI:         ki_q      = data;
			CFG_KD:         kd_q      = data;
			CFG_OUT_MIN:    lo_lim_q  = data;
			CFG_OUT_MAX:    hi_lim_q  = data;
			CFG_HALF_TS:    half_ts_q = data[30:0];
			CFG_BETA:       beta_q    = data[17:0];
			CFG_DERIV_GAIN: dgain_q   = data;
			default: ;
		endcase
	endtask

	task automatic load_settings(input reg_set_t rs);
		write_reg(CFG_KP, rs.kp);
		write_reg(CFG_KI, rs.ki);
		write_reg(CFG_KD, rs.kd);
		write_reg(CFG_OUT_MIN, rs.out_min);
		write_reg(CFG_OUT_MAX, rs.out_max);
		write_reg(CFG_HALF_TS, rs.half_ts);
		write_reg(CFG_BETA, rs.beta);
		write_reg(CFG_DERIV_GAIN, rs.deriv_gain);
		cfg_we <= 1'b0;
	endtask

	// Lowers valid and waits until every owed word has come back, then lets the
	// settle time pass. A reset word gives nothing back and adds no owed word.
	task automatic drain_block();
		in_valid <= 1'b0;
		while (control_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Offers one word, holds it steady until it is taken, and records what
	// the block owes for it.
	task automatic offer_word(
		input logic        f,
		input logic [31:0] sp,
		input logic [31:0] ms,
		input bit          known,
		input logic [31:0] want
	);
		logic signed [31:0] u;
		bit                 gives;
		in_valid    <= 1'b1;
		func        <= f;
		setpoint    <= sp;
		measurement <= ms;
		do begin
			@(posedge clk);
		end while (in_stall);
		gives = predict_control(f, sp, ms, u);
		if (gives) begin
			control_due.push_back(known ? want : u);
		end
	endtask

	// A random idle burst on the sending side, now and then.
	task automatic sender_idle();
		if (!quiet && !burst_mode && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// Field values: mostly small, often full-width, sometimes the extremes.
	function automatic logic [31:0] rand_sample();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0:       return 32'h8000_0000;
					1:       return 32'h7fff_ffff;
					2:       return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			1, 2, 3: return $urandom;
			default: return $signed($urandom) >>> $urandom_range(8, 24);
		endcase
	endfunction

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(0, 7))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0000_0000;
			3, 4:    return $urandom;
			default: return $signed($urandom) >>> $urandom_range(8, 18);
		endcase
	endfunction

	function automatic reg_set_t rand_settings();
		reg_set_t           rs;
		logic signed [31:0] a, b;
		logic signed [17:0] bv;
		rs.kp         = rand_gain();
		rs.ki         = rand_gain();
		rs.kd         = rand_gain();
		rs.deriv_gain = rand_gain();
		a = $signed($urandom) >>> $urandom_range(4, 16);
		b = $signed($urandom) >>> $urandom_range(4, 16);
		case ($urandom_range(0, 7))
			0: begin
				rs.out_min = 32'h8000_0000;
				rs.out_max = 32'h7fff_ffff;
			end
			1: begin
				// Crossed limits.
				rs.out_min = (a > b) ? a : b;
				rs.out_max = (a > b) ? b : a;
			end
			default: begin
				rs.out_min = (a > b) ? b : a;
				rs.out_max = (a > b) ? a : b;
			end
		endcase
		case ($urandom_range(0, 5))
			0:       rs.half_ts = 32'h0000_0000;
			1:       rs.half_ts = 32'h7fff_ffff;
			2:       rs.half_ts = $urandom;
			default: rs.half_ts = {$urandom_range(0, 1) == 1, 31'($urandom_range(0, 32'h3000))};
		endcase
		case ($urandom_range(0, 5))
			0:       bv = 18'sd65536;
			1:       bv = -18'sd65536;
			2:       bv = 18'sd0;
			default: bv = 18'($urandom_range(0, 131072) - 65536);
		endcase
		rs.beta = {{14{bv[17]}}, bv};
		// The bits above the filter pole are not part of the register.
		if ($urandom_range(0, 7) == 0) begin
			rs.beta[31:18] = 14'($urandom);
		end
		return rs;
	endfunction

	// Receiver: random stall bursts, one long hold-off on request, and no
	// stalling at all once the run is in its quiet tail.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
				out_stall <= 1'b0;
			end else if (quiet || $urandom_range(0, 2) != 0) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(0, 13)) @(posedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(0, 13)) @(posedge clk);
			end
		end
	end

	// Every accepted control word is checked against the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (control_due.size() == 0) begin
				$error("control_out: unexpected word, expected none, actual %0d", control_out);
				fail_count++;
			end else begin
				if (control_out !== control_due[0]) begin
					$error("control_out mismatch: expected %0d, actual %0d",
						control_due[0], control_out);
					fail_count++;
				end
				void'(control_due.pop_front());
			end
		end
	end

	// Watchdog: counts cycles in which no word is taken on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int          ph, k;
		logic [2:0]  cur_set;
		dir_row_t    row;
		logic        f;
		logic [31:0] sp, ms, hold_sp;

		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= CFG_KP;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		func        <= FUNC_UPDATE;
		setpoint    <= '0;
		measurement <= '0;

		// Predictor starts from the reset defaults: zero gains, full limits.
		kp_q       = '0;
		ki_q       = '0;
		kd_q       = '0;
		lo_lim_q   = 32'h8000_0000;
		hi_lim_q   = 32'h7fff_ffff;
		half_ts_q  = '0;
		beta_q     = '0;
		dgain_q    = '0;
		prev_err_q = '0;
		rate_q     = '0;
		integ_q    = '0;

		// Settings used by the directed table. Set 0 is the reset state and
		// is never written; set 3 has its limits crossed; sets 4 and 5 put
		// every register at an extreme so that the wide terms saturate.
		dir_sets = '{
			'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000,
				32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
			'{32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000,
				32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
			'{32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'hffff_0000,
				32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
			'{32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0002_0000,
				32'hfffe_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
			'{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
				32'h7fff_ffff, 32'h7fff_ffff, 32'h0001_0000, 32'h7fff_ffff},
			'{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
				32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_0000, 32'h8000_0000},
			'{32'h0002_0000, 32'h0000_8000, 32'h0000_1999, 32'hfff6_0000,
				32'h000a_0000, 32'h0000_0148, 32'h0000_e666, 32'h0003_0000}
		};

		// With only kp at one, the output is the error itself, which makes the
		// first few settings easy to read by eye.
		dir_rows = '{
			'{3'd0, FUNC_UPDATE, 32'h0005_0000, 32'h0001_0000, 1'b1, 32'h0000_0000},
			'{3'd0, FUNC_UPDATE, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 32'h0000_0000},
			'{3'd0, FUNC_RESET,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
			'{3'd1, FUNC_UPDATE, 32'h0003_0000, 32'h0001_0000, 1'b1, 32'h0002_0000},
			'{3'd1, FUNC_UPDATE, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 32'h7fff_ffff},
			'{3'd1, FUNC_UPDATE, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 32'h8000_0000},
			'{3'd1, FUNC_UPDATE, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
			'{3'd1, FUNC_UPDATE, 32'hffff_ffff, 32'h0000_0000, 1'b1, 32'hffff_ffff},
			'{3'd2, FUNC_UPDATE, 32'h0005_0000, 32'h0000_0000, 1'b1, 32'h0001_0000},
			'{3'd2, FUNC_UPDATE, 32'h0000_0000, 32'h0005_0000, 1'b1, 32'hffff_0000},
			'{3'd2, FUNC_UPDATE, 32'h0000_8000, 32'h0000_0000, 1'b1, 32'h0000_8000},
			'{3'd3, FUNC_UPDATE, 32'h0005_0000, 32'h0000_0000, 1'b1, 32'h0002_0000},
			'{3'd3, FUNC_UPDATE, 32'h0000_0000, 32'h0005_0000, 1'b1, 32'h0002_0000},
			'{3'd4, FUNC_UPDATE, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 32'h0000_0000},
			'{3'd4, FUNC_UPDATE, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 32'h0000_0000},
			'{3'd4, FUNC_UPDATE, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 32'h0000_0000},
			'{3'd4, FUNC_RESET,  32'h7fff_ffff, 32'h8000_0000, 1'b0, 32'h0000_0000},
			'{3'd4, FUNC_UPDATE, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
			'{3'd4, FUNC_UPDATE, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 32'h0000_0000},
			'{3'd5, FUNC_UPDATE, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 32'h0000_0000},
			'{3'd5, FUNC_UPDATE, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 32'h0000_0000},
			'{3'd5, FUNC_UPDATE, 32'h1234_5678, 32'h8765_4321, 1'b0, 32'h0000_0000},
			'{3'd6, FUNC_RESET,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
			'{3'd6, FUNC_UPDATE, 32'h0001_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
			'{3'd6, FUNC_UPDATE, 32'h0001_0000, 32'h0000_4000, 1'b0, 32'h0000_0000}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. Settings only change once the block has gone idle.
		cur_set = 3'd0;
		for (k = 0; k < N_DIR_ROWS; k++) begin
			row = dir_rows[k];
			if (row.set_no != cur_set) begin
				drain_block();
				load_settings(dir_sets[row.set_no]);
				cur_set = row.set_no;
			end
			offer_word(row.f, row.sp, row.ms, row.known, row.want);
			sender_idle();
		end

		// Random part: each phase runs under fresh settings. Most words follow
		// a held setpoint with a measurement close to it, as a real loop would,
		// with reset words and unrelated values mixed in.
		hold_sp = rand_sample();
		for (ph = 0; ph < N_PHASES; ph++) begin
			drain_block();
			load_settings(rand_settings());
			if (ph == N_PHASES - 1) begin
				quiet = 1'b1;
			end
			for (k = 0; k < PHASE_WORDS; k++) begin
				// In the second phase the receiver holds off for a long stretch
				// while words keep coming, so the block fills and stalls its input.
				if (ph == 1 && k == 0) begin
					long_hold  = 1'b1;
					burst_mode = 1'b1;
				end
				if (ph == 1 && k == 40) begin
					burst_mode = 1'b0;
				end
				// Half-way through the fourth phase the sender waits for every
				// owed word before going on.
				if (ph == 3 && k == PHASE_WORDS / 2) begin
					in_valid <= 1'b0;
					while (control_due.size() != 0) begin
						@(posedge clk);
					end
				end
				if ($urandom_range(0, 7) == 0) begin
					hold_sp = rand_sample();
				end
				f  = ($urandom_range(0, 11) == 0) ? FUNC_RESET : FUNC_UPDATE;
				sp = ($urandom_range(0, 4) == 0) ? rand_sample() : hold_sp;
				if ($urandom_range(0, 3) != 0) begin
					ms = sp - ($signed($urandom) >>> $urandom_range(10, 28));
				end else begin
					ms = rand_sample();
				end
				offer_word(f, sp, ms, 1'b0, 32'h0);
				sender_idle();
			end
		end

		in_valid <= 1'b0;
		while (control_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (3 * SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0 && control_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/pidd_pkg.sv
hw/rtl/pidd_mul.sv
hw/rtl/pid_dirty_derivative_saturating.sv
tb/tb_pid_dirty_derivative_saturating.sv
